### rtl/dnf_pkg.sv
// dnf_pkg: shared constants, item types and helper functions of the
// four-neighbour despeckle filter; depends on nothing
`default_nettype none

package dnf_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int PIX_W     = 8;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 8;
  localparam int GLYPH_W   = 7;
  localparam int SLOT_W    = 2;
  localparam int ROW_SLOTS = 3;
  localparam int RAM_DEPTH = ROW_SLOTS * MAX_WIDTH;
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int SUM_W     = PIX_W + 2;
  localparam int CNT_W     = 3;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 8;

  // divide by six as multiply by 683 and shift by 12, exact below 2048
  localparam int RECIP6   = 683;
  localparam int RECIP6_W = 10;
  localparam int RECIP6_SH = 12;
  localparam int PROD_W   = SUM_W + 1 + RECIP6_W;

  localparam logic [COL_W-1:0]   MIN_WIDTH  = 6'd2;
  localparam logic [ROW_W-1:0]   MIN_HEIGHT = 8'd2;
  localparam logic [COL_W-1:0]   RST_WIDTH  = 6'd30;
  localparam logic [ROW_W-1:0]   RST_HEIGHT = 8'd20;
  localparam logic [PIX_W-1:0]   RST_LIMIT  = 8'd1;

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DIFF_LIMIT   = 2'd2;

  localparam logic [PIX_W-1:0]   DIGIT_ZERO    = 8'd48;
  localparam logic [PIX_W-1:0]   DIGIT_NINE    = 8'd57;
  localparam logic [GLYPH_W-1:0] GLYPH_DEFAULT = 7'd101;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_MID   = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd2;

  localparam logic [CNT_W-1:0] NB_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] NB_THREE = 3'd3;
  localparam logic [CNT_W-1:0] NB_FOUR  = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [GLYPH_W-1:0] glyph;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               run_last;
    logic               frame_done;
  } out_item_t;

  // one pixel to be filtered, handed from the sequencer to the datapath
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_up;
    logic             has_down;
    logic             has_right;
    logic             run_last;
    logic             frame_done;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] head;
  } calc_item_t;

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    case (s)
      SLOT_FIRST: r = SLOT_LAST;
      SLOT_MID:   r = SLOT_FIRST;
      SLOT_LAST:  r = SLOT_MID;
      default:    r = SLOT_FIRST;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    case (s)
      SLOT_FIRST: r = SLOT_MID;
      SLOT_MID:   r = SLOT_LAST;
      default:    r = SLOT_FIRST;
    endcase
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [PIX_W-1:0] v);
    logic [GLYPH_W-1:0] g;
    if (v < DIGIT_ZERO || v > DIGIT_NINE) begin
      g = GLYPH_DEFAULT;
    end else begin
      case (v - DIGIT_ZERO)
        8'd0:    g = 7'd32;
        8'd1:    g = 7'd46;
        8'd2:    g = 7'd45;
        8'd3:    g = 7'd44;
        8'd4:    g = 7'd34;
        8'd5:    g = 7'd43;
        8'd6:    g = 7'd33;
        8'd7:    g = 7'd36;
        8'd8:    g = 7'd37;
        8'd9:    g = 7'd35;
        default: g = GLYPH_DEFAULT;
      endcase
    end
    return g;
  endfunction

endpackage

`default_nettype wire

### rtl/dnf_in_if.sv
// dnf_in_if: valid/ready channel carrying one input pixel item
// depends on dnf_pkg
`default_nettype none

interface dnf_in_if;
  logic               valid;
  logic               ready;
  dnf_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/dnf_out_if.sv
// dnf_out_if: valid/ready channel carrying one filtered pixel item
// depends on dnf_pkg
`default_nettype none

interface dnf_out_if;
  logic               valid;
  logic               ready;
  dnf_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/dnf_ram.sv
// dnf_ram: generic simple dual-port ram, one write port and one read port
// with registered read data; no dependencies
`default_nettype none

module dnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/dnf_seq.sv
// dnf_seq: frame position tracking, line buffer write and read addressing,
// and the end-of-frame flush of the last row; depends on dnf_pkg, dnf_in_if
`default_nettype none

module dnf_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       restart,
  input  wire logic [dnf_pkg::COL_W-1:0]  eff_w,
  input  wire logic [dnf_pkg::ROW_W-1:0]  eff_h,
  dnf_in_if.sink                          pixels,
  input  wire logic                       can_issue,
  output      logic                       issue,
  output      dnf_pkg::calc_item_t        item,
  output      logic                       ram_we,
  output      logic [dnf_pkg::ADDR_W-1:0] ram_waddr,
  output      logic [dnf_pkg::PIX_W-1:0]  ram_wdata,
  output      logic                       ram_re,
  output      logic [dnf_pkg::ADDR_W-1:0] mid_raddr,
  output      logic [dnf_pkg::ADDR_W-1:0] up_raddr
);
  import dnf_pkg::*;

  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] cur_slot;
  logic              flushing;
  logic [COL_W-1:0]  fl_col;
  logic [PIX_W-1:0]  head;
  logic [SLOT_W-1:0] fl_mid;
  logic [SLOT_W-1:0] fl_up;
  logic [ROW_W-1:0]  fl_row;

  logic              wrap_pos;
  logic [COL_W-1:0]  c_cur;
  logic [ROW_W-1:0]  r_cur;
  logic [SLOT_W-1:0] s_cur;
  logic [SLOT_W-1:0] mid_s;
  logic [SLOT_W-1:0] up_s;
  logic              accept;
  logic              col_last;
  logic              row_last;
  logic              final_px;
  logic              fl_last;
  logic              fl_issue;

  assign wrap_pos = (in_col >= eff_w) || (in_row >= eff_h);
  assign c_cur    = wrap_pos ? '0 : in_col;
  assign r_cur    = wrap_pos ? '0 : in_row;
  assign s_cur    = wrap_pos ? SLOT_FIRST : cur_slot;
  assign mid_s    = slot_prev(s_cur);
  assign up_s     = slot_prev(mid_s);

  assign pixels.ready = !flushing && can_issue;
  assign accept   = pixels.valid && pixels.ready;
  assign col_last = (c_cur + 1'b1) == eff_w;
  assign row_last = (r_cur + 1'b1) == eff_h;
  assign final_px = col_last && row_last;
  assign fl_last  = (fl_col + 1'b1) == eff_w;
  assign fl_issue = flushing && can_issue;

  assign issue = (accept && (r_cur != '0)) || fl_issue;

  assign ram_we    = accept;
  assign ram_waddr = {s_cur, c_cur};
  assign ram_wdata = pixels.item.pixel_in;
  assign ram_re    = issue;

  always_comb begin
    if (flushing) begin
      item.row        = fl_row;
      item.col        = fl_col;
      item.has_up     = 1'b1;
      item.has_down   = 1'b0;
      item.has_right  = !fl_last;
      item.run_last   = fl_last;
      item.frame_done = fl_last;
      item.down       = '0;
      mid_raddr       = {fl_mid, fl_col + 1'b1};
      up_raddr        = {fl_up, fl_col};
    end else begin
      item.row        = r_cur - 1'b1;
      item.col        = c_cur;
      item.has_up     = r_cur > 8'd1;
      item.has_down   = 1'b1;
      item.has_right  = !col_last;
      item.run_last   = !final_px;
      item.frame_done = 1'b0;
      item.down       = pixels.item.pixel_in;
      mid_raddr       = {mid_s, c_cur + 1'b1};
      up_raddr        = {up_s, c_cur};
    end
    item.head = head;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      cur_slot <= SLOT_FIRST;
      flushing <= 1'b0;
      fl_col   <= '0;
    end else begin
      if (accept) begin
        if (col_last) begin
          in_col <= '0;
          if (row_last) begin
            in_row   <= '0;
            cur_slot <= SLOT_FIRST;
          end else begin
            in_row   <= r_cur + 1'b1;
            cur_slot <= slot_next(s_cur);
          end
        end else begin
          in_col   <= c_cur + 1'b1;
          in_row   <= r_cur;
          cur_slot <= s_cur;
        end
        if (final_px) begin
          flushing <= 1'b1;
          fl_col   <= '0;
        end
      end
      if (fl_issue) begin
        fl_col <= fl_col + 1'b1;
        if (fl_last) begin
          flushing <= 1'b0;
        end
      end
      if (restart) begin
        in_col   <= '0;
        in_row   <= '0;
        cur_slot <= SLOT_FIRST;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (accept && (c_cur == '0)) begin
      head <= pixels.item.pixel_in;
    end
    if (accept && final_px) begin
      fl_row <= r_cur;
      fl_mid <= s_cur;
      fl_up  <= mid_s;
    end
  end

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !pixels.ready)
    else $error("input taken during flush");

  a_final_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && final_px) |=> flushing)
    else $error("frame end did not start flush");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (issue && item.frame_done) |-> (item.run_last && flushing))
    else $error("frame end item not last of its run");

endmodule

`default_nettype wire

### rtl/dnf_calc.sv
// dnf_calc: neighbour window, noise test, rounded neighbour mean and glyph
// lookup between the item and result registers; depends on dnf_pkg, dnf_out_if
`default_nettype none

module dnf_calc (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [dnf_pkg::PIX_W-1:0] diff_limit,
  input  wire logic                      issue,
  input  wire dnf_pkg::calc_item_t       item,
  output      logic                      can_issue,
  input  wire logic [dnf_pkg::PIX_W-1:0] mid_rd,
  input  wire logic [dnf_pkg::PIX_W-1:0] up_rd,
  dnf_out_if.source                      results
);
  import dnf_pkg::*;

  logic             a_valid;
  calc_item_t       a_item;
  logic [PIX_W-1:0] centre_r;
  logic [PIX_W-1:0] left_r;
  logic             o_valid;
  out_item_t        o_item;

  logic              a_adv;
  logic [PIX_W-1:0]  centre;
  logic              has_left;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  n;
  logic              noisy;
  logic [SUM_W:0]    x3;
  logic [PROD_W-1:0] prod3;
  logic [SUM_W-1:0]  q;
  logic [PIX_W-1:0]  v;

  assign a_adv     = a_valid && (!o_valid || results.ready);
  assign can_issue = !a_valid || a_adv;

  assign centre   = (a_item.col == '0) ? a_item.head : centre_r;
  assign has_left = a_item.col != '0;

  always_comb begin
    sum   = '0;
    n     = '0;
    noisy = 1'b0;
    if (a_item.has_up) begin
      sum   = sum + {2'b00, up_rd};
      n     = n + 1'b1;
      noisy = noisy || (abs_diff(centre, up_rd) > diff_limit);
    end
    if (a_item.has_down) begin
      sum   = sum + {2'b00, a_item.down};
      n     = n + 1'b1;
      noisy = noisy || (abs_diff(centre, a_item.down) > diff_limit);
    end
    if (has_left) begin
      sum   = sum + {2'b00, left_r};
      n     = n + 1'b1;
      noisy = noisy || (abs_diff(centre, left_r) > diff_limit);
    end
    if (a_item.has_right) begin
      sum   = sum + {2'b00, mid_rd};
      n     = n + 1'b1;
      noisy = noisy || (abs_diff(centre, mid_rd) > diff_limit);
    end
  end

  // mean rounded half up: (2*sum + n) / (2*n)
  assign x3    = {sum, 1'b0} + (SUM_W + 1)'(3);
  assign prod3 = PROD_W'(x3) * PROD_W'(RECIP6);

  always_comb begin
    case (n)
      NB_TWO:   q = (sum + 1'b1) >> 1;
      NB_THREE: q = SUM_W'(prod3 >> RECIP6_SH);
      NB_FOUR:  q = (sum + SUM_W'(2)) >> 2;
      default:  q = {2'b00, centre};
    endcase
    v = noisy ? q[PIX_W-1:0] : centre;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (issue) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_item <= item;
    end
    if (a_adv) begin
      left_r            <= centre;
      centre_r          <= mid_rd;
      o_item.pixel_out  <= v;
      o_item.glyph      <= glyph_of(v);
      o_item.out_row    <= a_item.row;
      o_item.out_col    <= a_item.col;
      o_item.run_last   <= a_item.run_last;
      o_item.frame_done <= a_item.frame_done;
    end
  end

  assign results.valid = o_valid;
  assign results.item  = o_item;

  a_issue_has_room: assert property (@(posedge clk) disable iff (rst)
    issue |-> can_issue)
    else $error("item issued into a full stage");

  a_neighbour_count: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (n >= NB_TWO && n <= NB_FOUR))
    else $error("pixel with fewer than two neighbours");

  a_result_advances: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> o_valid)
    else $error("computed item not presented");

endmodule

`default_nettype wire

### rtl/neighbor_despeckle_filter_core.sv
// neighbor_despeckle_filter_core: top level of the four-neighbour despeckle
// filter; depends on dnf_pkg, dnf_in_if, dnf_out_if, dnf_ram, dnf_seq, dnf_calc
//
// pixels carries one 8-bit pixel per item in raster order; results carries
// the filtered pixel with its glyph, row, column, run_last and frame_done.
// configuration: wr_en/wr_index/wr_data write frame_width (0), frame_height (1)
// and diff_limit (2); a geometry write restarts the frame at row 0, column 0.
// the input at row r >= 1, column c produces the result for row r-1, column c;
// row 0 inputs produce none. the frame's final input produces the result for
// the row above it and then the whole last row, one item per cycle unless the
// receiver stalls, while pixels.ready is held low.
// an accepted input passes through the item register and the result register.
// throughput: one item per cycle while the receiver takes results, set by
// the single write port and the two registered read ports of the three-row
// line buffer; the last-row flush issues one item per column of the frame.
// reset: frame position cleared, registers return to 30, 20 and 1; the line
// buffer is not cleared. a stalled receiver holds the result register and
// backs up through the item register to pixels.ready.
`default_nettype none

module neighbor_despeckle_filter_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  dnf_in_if.sink                         pixels,
  dnf_out_if.source                      results,
  input  wire logic                      wr_en,
  input  wire logic [dnf_pkg::IDX_W-1:0] wr_index,
  input  wire logic [dnf_pkg::CFG_W-1:0] wr_data
);
  import dnf_pkg::*;

  logic [COL_W-1:0] frame_width;
  logic [ROW_W-1:0] frame_height;
  logic [PIX_W-1:0] diff_limit;

  logic [COL_W-1:0]  eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic              restart;
  logic              can_issue;
  logic              issue;
  calc_item_t        item;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] mid_raddr;
  logic [ADDR_W-1:0] up_raddr;
  logic [PIX_W-1:0]  mid_rd;
  logic [PIX_W-1:0]  up_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_WIDTH;
      frame_height <= RST_HEIGHT;
      diff_limit   <= RST_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        CFG_FRAME_WIDTH:  frame_width  <= wr_data[COL_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= wr_data[ROW_W-1:0];
        CFG_DIFF_LIMIT:   diff_limit   <= wr_data[PIX_W-1:0];
        default:          ;
      endcase
    end
  end

  assign restart = wr_en && ((wr_index == CFG_FRAME_WIDTH) ||
                             (wr_index == CFG_FRAME_HEIGHT));
  assign eff_w   = (frame_width < MIN_WIDTH) ? MIN_WIDTH : frame_width;
  assign eff_h   = (frame_height < MIN_HEIGHT) ? MIN_HEIGHT : frame_height;

  dnf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .pixels    (pixels),
    .can_issue (can_issue),
    .issue     (issue),
    .item      (item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .mid_raddr (mid_raddr),
    .up_raddr  (up_raddr)
  );

  // two copies of the line buffer, one read port each
  dnf_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_ram_mid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mid_raddr),
    .rdata (mid_rd)
  );

  dnf_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_ram_up (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (up_raddr),
    .rdata (up_rd)
  );

  dnf_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .diff_limit (diff_limit),
    .issue      (issue),
    .item       (item),
    .can_issue  (can_issue),
    .mid_rd     (mid_rd),
    .up_rd      (up_rd),
    .results    (results)
  );

endmodule

`default_nettype wire
